@@ hw/rtl/c65alu_pkg.sv @@
// ----------------------------------------------------------------------------
// c65alu_pkg: shared types and constants of the 6502 ALU and register unit
// Operation codes, status flag positions, the register file record and the
// reset value of the status byte.
// ----------------------------------------------------------------------------
package c65alu_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [5:0] op_code_t;

  typedef enum op_code_t {
    OP_LDA = 6'd0,  OP_LDX = 6'd1,  OP_LDY = 6'd2,
    OP_STA = 6'd3,  OP_STX = 6'd4,  OP_STY = 6'd5,
    OP_TAX = 6'd6,  OP_TAY = 6'd7,  OP_TXA = 6'd8,
    OP_TYA = 6'd9,  OP_TSX = 6'd10, OP_TXS = 6'd11,
    OP_AND = 6'd12, OP_EOR = 6'd13, OP_ORA = 6'd14, OP_BIT = 6'd15,
    OP_ADC = 6'd16, OP_SBC = 6'd17, OP_CMP = 6'd18,
    OP_CPX = 6'd19, OP_CPY = 6'd20,
    OP_INC = 6'd21, OP_INX = 6'd22, OP_INY = 6'd23,
    OP_DEC = 6'd24, OP_DEX = 6'd25, OP_DEY = 6'd26,
    OP_ASL = 6'd27, OP_LSR = 6'd28, OP_ROL = 6'd29, OP_ROR = 6'd30,
    OP_BCC = 6'd31, OP_BCS = 6'd32, OP_BEQ = 6'd33, OP_BMI = 6'd34,
    OP_BNE = 6'd35, OP_BPL = 6'd36, OP_BVC = 6'd37, OP_BVS = 6'd38,
    OP_CLC = 6'd39, OP_CLD = 6'd40, OP_CLI = 6'd41, OP_CLV = 6'd42,
    OP_SEC = 6'd43, OP_SED = 6'd44, OP_SEI = 6'd45, OP_NOP = 6'd46
  } op_t;

  // Bit positions inside the status byte.
  localparam int FLAG_C   = 0;
  localparam int FLAG_Z   = 1;
  localparam int FLAG_I   = 2;
  localparam int FLAG_D   = 3;
  localparam int FLAG_B   = 4;
  localparam int FLAG_ONE = 5;
  localparam int FLAG_V   = 6;
  localparam int FLAG_N   = 7;

  localparam byte_t STATUS_RESET = 8'h24;

  typedef struct packed {
    byte_t acc;
    byte_t x;
    byte_t y;
    byte_t sp;
    byte_t p;
  } regs_t;

  typedef struct packed {
    byte_t store_value;
    logic  store_enable;
    logic  branch_taken;
  } mem_res_t;

endpackage

@@ hw/rtl/c65alu_if.sv @@
// ----------------------------------------------------------------------------
// c65alu_if: request and response channels of the 6502 ALU unit
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface c65alu_req_if;
  logic                 valid;
  logic                 ready;
  c65alu_pkg::op_code_t req_type;
  c65alu_pkg::byte_t    operand;
  logic                 to_memory;

  modport source (output valid, output req_type, output operand, output to_memory,
                  input ready);
  modport sink   (input valid, input req_type, input operand, input to_memory,
                  output ready);
endinterface

interface c65alu_rsp_if;
  logic              valid;
  logic              ready;
  c65alu_pkg::byte_t store_value;
  logic              store_enable;
  logic              branch_taken;
  c65alu_pkg::byte_t acc_out;
  c65alu_pkg::byte_t xreg_out;
  c65alu_pkg::byte_t yreg_out;
  c65alu_pkg::byte_t sp_out;
  c65alu_pkg::byte_t status_out;

  modport source (output valid, output store_value, output store_enable,
                  output branch_taken, output acc_out, output xreg_out,
                  output yreg_out, output sp_out, output status_out,
                  input ready);
  modport sink   (input valid, input store_value, input store_enable,
                  input branch_taken, input acc_out, input xreg_out,
                  input yreg_out, input sp_out, input status_out,
                  output ready);
endinterface

@@ hw/rtl/cpu6502_alu_register_unit_core.sv @@
// ----------------------------------------------------------------------------
// cpu6502_alu_register_unit_core: 6502 ALU and register unit
// Executes one decoded 6502 register/ALU operation per beat and reports the
// memory write-back, the branch decision and the updated registers.
//
//   channel | dir | payload
//   --------+-----+----------------------------------------------------------
//   req     | in  | req_type, operand, to_memory
//   rsp     | out | store_value, store_enable, branch_taken, acc_out,
//           |     | xreg_out, yreg_out, sp_out, status_out
//
// One beat per cycle sustained while rsp is ready; a taken request waits in the
// input register; its commit loads the result register and raises rsp.valid.
// The execute logic sits between the input register and the result register
// and updates the register file in the same edge the result is loaded.
// Reset clears A, X, Y and SP and sets the status byte to 0x24.
// A stalled rsp holds its beat while one more request still enters the
// input register; req.ready drops only when both registers are full.
// ----------------------------------------------------------------------------
module cpu6502_alu_register_unit_core (
  input logic          clk,
  input logic          rst,
  c65alu_req_if.sink   req,
  c65alu_rsp_if.source rsp
);
  import c65alu_pkg::*;

  logic     in_valid;
  op_code_t in_type;
  byte_t    in_operand;
  logic     in_mem;
  logic     out_valid;
  logic     commit;
  regs_t    regs;
  regs_t    regs_next;
  mem_res_t res;

  assign commit    = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || commit;
  assign rsp.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.ready) begin
        in_valid <= req.valid;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_type    <= req.req_type;
      in_operand <= req.operand;
      in_mem     <= req.to_memory;
    end
  end

  c65alu_exec u_exec (
    .req_type  (in_type),
    .operand   (in_operand),
    .to_memory (in_mem),
    .regs      (regs),
    .regs_next (regs_next),
    .res       (res)
  );

  c65alu_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .commit    (commit),
    .regs_next (regs_next),
    .regs      (regs)
  );

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.store_value  <= res.store_value;
      rsp.store_enable <= res.store_enable;
      rsp.branch_taken <= res.branch_taken;
      rsp.acc_out      <= regs_next.acc;
      rsp.xreg_out     <= regs_next.x;
      rsp.yreg_out     <= regs_next.y;
      rsp.sp_out       <= regs_next.sp;
      rsp.status_out   <= regs_next.p;
    end
  end

`ifndef ASSERT_OFF
  // The register file only moves when an operation commits.
  a_regs_hold: assert property (@(posedge clk) disable iff (rst)
    !commit |=> $stable(regs))
    else $error("register file changed without a commit");

  // The beat loaded at a commit shows the register file it produced.
  a_rsp_matches_regs: assert property (@(posedge clk) disable iff (rst)
    commit |=> rsp.valid && rsp.acc_out == regs.acc && rsp.status_out == regs.p)
    else $error("response registers differ from the register file");

  // Fixed status bits on every response.
  a_status_fixed: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.status_out[FLAG_ONE] && !rsp.status_out[FLAG_B])
    else $error("status bit five or four has the wrong value");

  // Backpressure only when both the input and the result register are full.
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> in_valid && out_valid && !rsp.ready)
    else $error("request stalled with free room");
`endif

endmodule

@@ hw/rtl/c65alu_exec.sv @@
// ----------------------------------------------------------------------------
// c65alu_exec: single-pass execute logic
// Computes the next register file and the memory/branch result of one
// decoded operation from the current registers and the operand byte.
// ----------------------------------------------------------------------------
module c65alu_exec (
  input  c65alu_pkg::op_code_t req_type,
  input  c65alu_pkg::byte_t    operand,
  input  logic                 to_memory,
  input  c65alu_pkg::regs_t    regs,
  output c65alu_pkg::regs_t    regs_next,
  output c65alu_pkg::mem_res_t res
);
  import c65alu_pkg::*;

  logic [8:0] sum;
  logic [8:0] diff;
  byte_t      addend;
  byte_t      cmp_reg;
  byte_t      shift_src;
  byte_t      nz_val;
  logic       nz_en;
  byte_t      p;
  byte_t      sval;
  logic       sen;
  logic       br;
  logic       cin;

  always_comb begin
    regs_next = regs;
    p         = regs.p;
    cin       = regs.p[FLAG_C];
    nz_val    = '0;
    nz_en     = 1'b0;
    sval      = '0;
    sen       = 1'b0;
    br        = 1'b0;

    // SBC is ADC of the inverted operand.
    addend = (req_type == OP_SBC) ? ~operand : operand;
    sum    = {1'b0, regs.acc} + {1'b0, addend} + {8'd0, cin};

    case (req_type)
      OP_CPX:  cmp_reg = regs.x;
      OP_CPY:  cmp_reg = regs.y;
      default: cmp_reg = regs.acc;
    endcase
    // The borrow out of the 9-bit difference is clear when reg >= operand.
    diff = {1'b0, cmp_reg} - {1'b0, operand};

    shift_src = to_memory ? operand : regs.acc;

    case (req_type)
      OP_LDA: begin regs_next.acc = operand; nz_val = operand; nz_en = 1'b1; end
      OP_LDX: begin regs_next.x = operand; nz_val = operand; nz_en = 1'b1; end
      OP_LDY: begin regs_next.y = operand; nz_val = operand; nz_en = 1'b1; end
      OP_STA: begin sval = regs.acc; sen = 1'b1; end
      OP_STX: begin sval = regs.x; sen = 1'b1; end
      OP_STY: begin sval = regs.y; sen = 1'b1; end
      OP_TAX: begin regs_next.x = regs.acc; nz_val = regs.acc; nz_en = 1'b1; end
      OP_TAY: begin regs_next.y = regs.acc; nz_val = regs.acc; nz_en = 1'b1; end
      OP_TXA: begin regs_next.acc = regs.x; nz_val = regs.x; nz_en = 1'b1; end
      OP_TYA: begin regs_next.acc = regs.y; nz_val = regs.y; nz_en = 1'b1; end
      OP_TSX: begin regs_next.x = regs.sp; nz_val = regs.sp; nz_en = 1'b1; end
      OP_TXS: begin regs_next.sp = regs.x; end
      OP_AND: begin
        nz_val = regs.acc & operand; regs_next.acc = nz_val; nz_en = 1'b1;
      end
      OP_EOR: begin
        nz_val = regs.acc ^ operand; regs_next.acc = nz_val; nz_en = 1'b1;
      end
      OP_ORA: begin
        nz_val = regs.acc | operand; regs_next.acc = nz_val; nz_en = 1'b1;
      end
      OP_BIT: begin
        p[FLAG_Z] = ((regs.acc & operand) == 8'd0);
        p[FLAG_N] = operand[7];
        p[FLAG_V] = operand[6];
      end
      OP_ADC, OP_SBC: begin
        regs_next.acc = sum[7:0];
        nz_val        = sum[7:0];
        nz_en         = 1'b1;
        p[FLAG_C]     = sum[8];
        // Overflow when both inputs share a sign that the result lacks.
        p[FLAG_V]     = ~(regs.acc[7] ^ addend[7]) & (regs.acc[7] ^ sum[7]);
      end
      OP_CMP, OP_CPX, OP_CPY: begin
        p[FLAG_C] = ~diff[8];
        nz_val    = diff[7:0];
        nz_en     = 1'b1;
      end
      OP_INC: begin
        sval = operand + 8'd1; sen = 1'b1; nz_val = sval; nz_en = 1'b1;
      end
      OP_INX: begin
        regs_next.x = regs.x + 8'd1; nz_val = regs_next.x; nz_en = 1'b1;
      end
      OP_INY: begin
        regs_next.y = regs.y + 8'd1; nz_val = regs_next.y; nz_en = 1'b1;
      end
      OP_DEC: begin
        sval = operand - 8'd1; sen = 1'b1; nz_val = sval; nz_en = 1'b1;
      end
      OP_DEX: begin
        regs_next.x = regs.x - 8'd1; nz_val = regs_next.x; nz_en = 1'b1;
      end
      OP_DEY: begin
        regs_next.y = regs.y - 8'd1; nz_val = regs_next.y; nz_en = 1'b1;
      end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
        case (req_type)
          OP_ASL: begin p[FLAG_C] = shift_src[7]; nz_val = {shift_src[6:0], 1'b0}; end
          OP_ROL: begin p[FLAG_C] = shift_src[7]; nz_val = {shift_src[6:0], cin}; end
          OP_LSR: begin p[FLAG_C] = shift_src[0]; nz_val = {1'b0, shift_src[7:1]}; end
          default: begin p[FLAG_C] = shift_src[0]; nz_val = {cin, shift_src[7:1]}; end
        endcase
        nz_en = 1'b1;
        if (to_memory) begin
          sval = nz_val;
          sen  = 1'b1;
        end else begin
          regs_next.acc = nz_val;
        end
      end
      OP_BCC: br = ~regs.p[FLAG_C];
      OP_BCS: br = regs.p[FLAG_C];
      OP_BEQ: br = regs.p[FLAG_Z];
      OP_BMI: br = regs.p[FLAG_N];
      OP_BNE: br = ~regs.p[FLAG_Z];
      OP_BPL: br = ~regs.p[FLAG_N];
      OP_BVC: br = ~regs.p[FLAG_V];
      OP_BVS: br = regs.p[FLAG_V];
      OP_CLC: p[FLAG_C] = 1'b0;
      OP_CLD: p[FLAG_D] = 1'b0;
      OP_CLI: p[FLAG_I] = 1'b0;
      OP_CLV: p[FLAG_V] = 1'b0;
      OP_SEC: p[FLAG_C] = 1'b1;
      OP_SED: p[FLAG_D] = 1'b1;
      OP_SEI: p[FLAG_I] = 1'b1;
      default: begin end
    endcase

    if (nz_en) begin
      p[FLAG_Z] = (nz_val == 8'd0);
      p[FLAG_N] = nz_val[7];
    end
    p[FLAG_ONE] = 1'b1;
    p[FLAG_B]   = 1'b0;
    regs_next.p = p;

    res.store_value  = sval;
    res.store_enable = sen;
    res.branch_taken = br;
  end

endmodule

@@ hw/rtl/c65alu_regs.sv @@
// ----------------------------------------------------------------------------
// c65alu_regs: architectural register file
// Holds A, X, Y, SP and the status byte; loads a new set when an
// operation commits.
// ----------------------------------------------------------------------------
module c65alu_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              commit,
  input  c65alu_pkg::regs_t regs_next,
  output c65alu_pkg::regs_t regs
);
  import c65alu_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.acc <= '0;
      regs.x   <= '0;
      regs.y   <= '0;
      regs.sp  <= '0;
      regs.p   <= STATUS_RESET;
    end else if (commit) begin
      regs <= regs_next;
    end
  end

endmodule
